@@ hw/rtl/utf8d_pkg.sv @@
`default_nettype none

package utf8d_pkg;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned CNT_W     = 3;
    localparam int unsigned WIN_DEPTH = 4;

    localparam logic [CP_W-1:0] ERR_CP_RESET = 21'h00FFFD;
    localparam logic [CP_W-1:0] SURR_LO      = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI      = 21'h00DFFF;

    // Register map: byte address bit 2 selects the register.
    localparam logic REG_ERROR_CP = 1'b0;

    // Controller to datapath
    typedef struct packed {
        logic load;   // append the incoming item to the window
        logic emit;   // register the head result and drop its bytes
    } utf8d_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic has_result;  // head of window yields a result now
        logic is_last;     // that result is the final one for this item
        logic slot_free;   // output register can take a result this cycle
    } utf8d_status_t;

    // Sequence length implied by a lead byte; zero for a bad lead.
    function automatic logic [CNT_W-1:0] lead_len(input logic [7:0] b);
        logic [CNT_W-1:0] len;
        len = 3'd0;
        if (b[7] == 1'b0)
            len = 3'd1;
        else if (b[7:5] == 3'b110)
            len = 3'd2;
        else if (b[7:4] == 4'b1110)
            len = 3'd3;
        else if (b[7:3] == 5'b11110)
            len = 3'd4;
        return len;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/utf8d_datapath.sv @@
`default_nettype none

module utf8d_datapath
    import utf8d_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire utf8d_cmd_t         cmd,
    output utf8d_status_t           status,
    input  wire logic [7:0]         in_byte,
    input  wire logic               in_flush,
    input  wire logic [CP_W-1:0]    err_cp,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [CP_W-1:0]         out_cp,
    output logic [CNT_W-1:0]        out_count,
    output logic                    out_error,
    output logic                    out_last
);

    logic [7:0]       win_reg [WIN_DEPTH];
    logic [7:0]       win_next [WIN_DEPTH];
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             flush_reg, flush_next;

    logic             valid_reg, valid_next;
    logic [CP_W-1:0]  cp_reg, cp_next;
    logic [CNT_W-1:0] bc_reg, bc_next;
    logic             err_reg, err_next;
    logic             last_reg, last_next;

    logic [CNT_W-1:0] need;
    logic             complete;
    logic             cont_ok;
    logic [CP_W-1:0]  cp_asm;
    logic             surr;
    logic             bad;
    logic [CNT_W-1:0] take;
    logic [CNT_W-1:0] cnt_after;
    logic [7:0]       next_head;
    logic [CNT_W-1:0] need_after;

    // Evaluate the sequence at the head of the window
    always_comb
    begin
        need     = lead_len(win_reg[0]);
        complete = (need != 3'd0) && (cnt_reg >= need);
        cont_ok  = 1'b1;
        for (int i = 1; i < WIN_DEPTH; i++)
        begin
            if ((CNT_W'(i) < need) && (win_reg[i][7:6] != 2'b10))
                cont_ok = 1'b0;
        end
        unique case (need)
            3'd1:    cp_asm = {13'd0, win_reg[0]};
            3'd2:    cp_asm = {10'd0, win_reg[0][4:0], win_reg[1][5:0]};
            3'd3:    cp_asm = {5'd0, win_reg[0][3:0], win_reg[1][5:0], win_reg[2][5:0]};
            3'd4:    cp_asm = {win_reg[0][2:0], win_reg[1][5:0], win_reg[2][5:0],
                               win_reg[3][5:0]};
            default: cp_asm = '0;
        endcase
        surr = (cp_asm >= SURR_LO) && (cp_asm <= SURR_HI);
        bad  = (need == 3'd0) || !complete || !cont_ok || surr;
        take = bad ? 3'd1 : need;

        status.has_result = (cnt_reg != 3'd0)
                          && ((need == 3'd0) || complete || flush_reg);

        // Look ahead at the next head to tell whether this result ends the run
        cnt_after  = cnt_reg - take;
        next_head  = win_reg[take[1:0]];
        need_after = lead_len(next_head);
        status.is_last = (cnt_after == 3'd0)
                       || (!flush_reg && (need_after != 3'd0) && (cnt_after < need_after));
        status.slot_free = !valid_reg || out_ready;
    end

    always_comb
    begin
        win_next   = win_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        valid_next = valid_reg && !out_ready;
        cp_next    = cp_reg;
        bc_next    = bc_reg;
        err_next   = err_reg;
        last_next  = last_reg;

        if (cmd.load)
        begin
            win_next[cnt_reg[1:0]] = in_byte;
            cnt_next               = cnt_reg + 3'd1;
            flush_next             = in_flush;
        end
        else if (cmd.emit)
        begin
            // Shift the window down by the bytes consumed
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                if ((i + int'(take)) < WIN_DEPTH)
                    win_next[i] = win_reg[i + int'(take)];
            end
            cnt_next   = cnt_after;
            valid_next = 1'b1;
            cp_next    = bad ? err_cp : cp_asm;
            bc_next    = take;
            err_next   = bad;
            last_next  = status.is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        cp_reg   <= cp_next;
        bc_reg   <= bc_next;
        err_reg  <= err_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_cp    = cp_reg;
    assign out_count = bc_reg;
    assign out_error = err_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/utf8d_ctrl.sv @@
`default_nettype none

module utf8d_ctrl
    import utf8d_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire utf8d_status_t status,
    output utf8d_cmd_t         cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.emit   = (state_reg == ST_SCAN) && status.has_result && status.slot_free;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // Return once the window holds nothing more to report
                if (!status.has_result)
                    state_next = ST_IDLE;
                else if (status.slot_free && status.is_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/utf8_stream_decoder.sv @@
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+---------------------------------------------
// s_*       | in  | s_tvalid/s_tready  | tdata[7:0] data_byte, tlast end_of_data
// m_*       | out | m_tvalid/m_tready  | tdata codepoint, char_len; tuser is_error;
//           |     |                    | tlast last_of_run
// APB       | in  | psel/penable       | reg 0 @ 0x0: error_codepoint[20:0]
//
// An item is accepted, then the results it completes are emitted in turn;
// no new item is accepted until the last of them is emitted. The head-of-window
// evaluate-and-shift step, one result per cycle, sets the rate.
// A full output register stalls that step until m_tready frees it; the
// output register lets the next item be accepted while a result waits.
// rst_n clears the window count and control state; error_codepoint resets to 0xFFFD.
`default_nettype none

module utf8_stream_decoder
    import utf8d_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,   // end_of_data
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [20:0] codepoint, [23:21] char_len
    output logic             m_tuser,   // [0] is_error
    output logic             m_tlast,   // last_of_run
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    utf8d_cmd_t       cmd;
    utf8d_status_t    status;
    logic [CP_W-1:0]  err_cp_reg, err_cp_next;
    logic [CP_W-1:0]  out_cp;
    logic [CNT_W-1:0] out_count;

    // Configuration register: written on the access phase, reads back as stored
    assign pready = 1'b1;

    always_comb
    begin
        err_cp_next = err_cp_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_ERROR_CP))
            err_cp_next = pwdata[CP_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_cp_reg <= ERR_CP_RESET;
        else
            err_cp_reg <= err_cp_next;
    end

    assign prdata = (paddr[2] == REG_ERROR_CP) ? {11'd0, err_cp_reg} : 32'd0;

    // Sequencer: accept an item, then walk the window one result at a time
    utf8d_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Window, head decode and output register
    utf8d_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_byte   (s_tdata),
        .in_flush  (s_tlast),
        .err_cp    (err_cp_reg),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_cp    (out_cp),
        .out_count (out_count),
        .out_error (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {out_count, out_cp};

endmodule

`default_nettype wire

@@ hw/rtl/utf8d_checker.sv @@
`default_nettype none

module utf8d_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output item changed while stalled");

    // Byte count is always 1 to 4
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:21] != 3'd0) && ((m_tdata[23] == 1'b0)
                     || (m_tdata[23:21] == 3'd4)))
        else $error("char_len out of range");

    // An error consumes exactly one byte
    a_err_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[23:21] == 3'd1)
        else $error("error result with char_len other than 1");

    // After taking an item the block works on it before taking another
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ verif/tb_utf8_stream_decoder.sv @@
`default_nettype none

module tb_utf8_stream_decoder;
    import utf8d_pkg::*;

    // Register addresses: bit 2 of paddr picks the register, so 0x4 maps to nothing.
    localparam logic [2:0] ADDR_ERROR_CP = 3'h0;
    localparam logic [2:0] ADDR_UNMAPPED = 3'h4;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int IDLE_PERCENT  = 27;
    localparam int PHASE_ITEMS   = 64;
    localparam int NUM_PHASES    = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_MAX    = 10;

    // One decoded result, in the order of the output fields.
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [CNT_W-1:0] cnt;
        logic             err;
        logic             last;
    } cp_result_t;

    // One row of the directed table. A typed row carries its expected result.
    typedef struct {
        logic [7:0] data;
        logic       eod;
        bit         typed;
        cp_result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Decoder shadow state: byte window and the current error codepoint.
    logic [7:0]      window_q[$];
    logic [CP_W-1:0] err_cp = ERR_CP_RESET;

    // Results predicted but not yet seen on the output stream.
    cp_result_t decoded_q[$];
    stim_row_t  dir_rows[$];

    bit calm = 1'b0;     // suppress idling on both sides
    int mismatches = 0;
    int results_seen = 0;
    int error_results = 0;
    int items_sent = 0;
    int config_writes = 0;
    int cycles = 0;

    utf8_stream_decoder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .s_tlast  (s_tlast),   // end_of_data
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [20:0] codepoint, [23:21] char_len
        .m_tuser  (m_tuser),   // [0] is_error
        .m_tlast  (m_tlast),   // last_of_run
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block wedges.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycles, decoded_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sequence length from a lead byte; zero for a stray continuation or 11111xxx.
    function automatic int seq_len(input logic [7:0] lead);
        casez (lead)
            8'b0???????: return 1;
            8'b110?????: return 2;
            8'b1110????: return 3;
            8'b11110???: return 4;
            default:     return 0;
        endcase
    endfunction

    // Append one byte to the window and pull every result it completes.
    // With keep cleared the state still advances but nothing is queued.
    task automatic decode_byte(input logic [7:0] data, input logic eod, input bit keep);
        cp_result_t  run[$];
        cp_result_t  r;
        logic [7:0]  lead;
        logic [31:0] acc;
        int          need;
        int          i;
        bit          bad;
        if (window_q.size() < WIN_DEPTH)
            window_q.push_back(data);
        while (window_q.size() > 0 && run.size() < WIN_DEPTH)
        begin
            lead = window_q[0];
            need = seq_len(lead);
            bad  = 1'b0;
            acc  = '0;
            if (need == 0)
                bad = 1'b1;
            else if (window_q.size() < need)
            begin
                // incomplete head: wait for more bytes unless this is a flush
                if (!eod)
                    break;
                bad = 1'b1;
            end
            else
            begin
                case (need)
                    1:       acc = {24'd0, lead};
                    2:       acc = {27'd0, lead[4:0]};
                    3:       acc = {28'd0, lead[3:0]};
                    default: acc = {29'd0, lead[2:0]};
                endcase
                for (i = 1; i < need; i++)
                begin
                    if (window_q[i][7:6] != 2'b10)
                        bad = 1'b1;
                    acc = (acc << 6) | {26'd0, window_q[i][5:0]};
                end
                if (acc >= SURR_LO && acc <= SURR_HI)
                    bad = 1'b1;
            end
            if (bad)
            begin
                // malformed: report the error value and drop the lead only
                r = '{cp: err_cp, cnt: 3'd1, err: 1'b1, last: 1'b0};
                void'(window_q.pop_front());
            end
            else
            begin
                r = '{cp: acc[CP_W-1:0], cnt: need[CNT_W-1:0], err: 1'b0, last: 1'b0};
                repeat (need) void'(window_q.pop_front());
            end
            run.push_back(r);
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        if (keep)
            foreach (run[k])
                decoded_q.push_back(run[k]);
    endtask

    // Offer one item, hold it until accepted, then advance the shadow decoder.
    // After the handshake tvalid stays high until settle or an idle lowers it.
    task automatic send_item(input logic [7:0] data, input logic eod, input bit keep);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= eod;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        decode_byte(data, eod, keep);
    endtask

    // Drop valid, wait until every expected result is out, then wait
    // SETTLE_CYCLES more for an item that completes nothing.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (decoded_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_ERROR_CP)
            err_cp = value[CP_W-1:0];
        config_writes++;
        @(posedge clk);
    endtask

    task automatic add_row(input logic [7:0] data, input logic eod, input bit typed,
                           input logic [CP_W-1:0] cp, input logic [CNT_W-1:0] cnt,
                           input logic err);
        stim_row_t row;
        row.data  = data;
        row.eod   = eod;
        row.typed = typed;
        row.res   = '{cp: cp, cnt: cnt, err: err, last: 1'b1};
        dir_rows.push_back(row);
    endtask

    function automatic logic [7:0] lead_for(input int len, input logic [31:0] rnd);
        case (len)
            2:       return {3'b110, rnd[4:0]};
            3:       return {4'b1110, rnd[3:0]};
            default: return {5'b11110, rnd[2:0]};
        endcase
    endfunction

    // Send one random unit: mostly well-formed sequences with random payload,
    // the rest broken or truncated sequences and raw noise bytes.
    task automatic send_random_unit(inout int sent);
        logic [7:0]  seq[$];
        logic [31:0] rnd;
        int          kind;
        int          len;
        int          i;
        bit          cut_short;
        bit          eod_tail;
        kind      = $urandom_range(0, 99);
        rnd       = $urandom;
        cut_short = 1'b0;
        if (kind < 30)
            seq.push_back({1'b0, rnd[6:0]});
        else if (kind < 88)
        begin
            if (kind < 75)
                len = (kind < 45) ? 2 : (kind < 60) ? 3 : 4;
            else
                len = $urandom_range(2, 4);
            seq.push_back(lead_for(len, rnd));
            // steer some 3-byte sequences into the surrogate neighborhood
            if (len == 3 && rnd[31:30] == 2'b00)
                seq[0] = 8'hED;
            for (i = 1; i < len; i++)
            begin
                rnd = $urandom;
                seq.push_back({2'b10, rnd[5:0]});
            end
            if (kind >= 75)
            begin
                if ($urandom_range(0, 1) == 1)
                    seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
                else
                begin
                    cut_short = 1'b1;
                    len = $urandom_range(1, len - 1);
                    while (seq.size() > len)
                        void'(seq.pop_back());
                end
            end
        end
        else
            seq.push_back(rnd[15:8]);
        eod_tail = cut_short ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) < 6);
        foreach (seq[j])
        begin
            send_item(seq[j], (j == seq.size() - 1) && eod_tail, 1'b1);
            sent++;
        end
    endtask

    // Output side: check each accepted result against the oldest expectation,
    // then pick tready for the next cycle.
    always @(posedge clk)
    begin : out_check
        cp_result_t got;
        cp_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{cp: m_tdata[20:0], cnt: m_tdata[23:21], err: m_tuser, last: m_tlast};
            results_seen++;
            if (got.err)
                error_results++;
            if (decoded_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: cp=%h cnt=%0d err=%b last=%b",
                             got.cp, got.cnt, got.err, got.last);
            end
            else
            begin
                want = decoded_q.pop_front();
                if (got.cp !== want.cp || got.cnt !== want.cnt ||
                    got.err !== want.err || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("mismatch at result %0d: exp cp=%h cnt=%0d err=%b last=%b, got cp=%h cnt=%0d err=%b last=%b",
                                 results_seen, want.cp, want.cnt, want.err, want.last,
                                 got.cp, got.cnt, got.err, got.last);
                end
            end
        end
        m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    initial
    begin : stimulus
        int         phase;
        int         sent;
        logic [31:0] rnd;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= ADDR_ERROR_CP;
        pwdata   <= 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, error codepoint still at its reset value.
        add_row(8'h00, 1'b0, 1'b1, 21'h000000, 3'd1, 1'b0);  // smallest ASCII
        add_row(8'h7F, 1'b0, 1'b1, 21'h00007F, 3'd1, 1'b0);  // largest ASCII
        add_row(8'h80, 1'b0, 1'b1, 21'h00FFFD, 3'd1, 1'b1);  // stray continuation as lead
        add_row(8'hFF, 1'b0, 1'b1, 21'h00FFFD, 3'd1, 1'b1);  // eight leading ones
        add_row(8'hC1, 1'b0, 1'b0, '0, '0, 1'b0);            // overlong 2-byte, accepted
        add_row(8'hBF, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hED, 1'b0, 1'b0, '0, '0, 1'b0);            // just below the surrogates
        add_row(8'h9F, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hBF, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hF0, 1'b0, 1'b0, '0, '0, 1'b0);            // 4-byte emoji
        add_row(8'h9F, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'h98, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'h80, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hED, 1'b0, 1'b0, '0, '0, 1'b0);            // surrogate: three errors
        add_row(8'hA0, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'h80, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hF7, 1'b0, 1'b0, '0, '0, 1'b0);            // largest 4-byte value
        add_row(8'hBF, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hBF, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hBF, 1'b0, 1'b1, 21'h1FFFFF, 3'd4, 1'b0);
        add_row(8'hC3, 1'b0, 1'b0, '0, '0, 1'b0);            // bad continuation, then 'A'
        add_row(8'h41, 1'b0, 1'b0, '0, '0, 1'b0);
        add_row(8'hF0, 1'b0, 1'b0, '0, '0, 1'b0);            // cut short by end of data
        add_row(8'h90, 1'b1, 1'b0, '0, '0, 1'b0);
        foreach (dir_rows[r])
        begin
            send_item(dir_rows[r].data, dir_rows[r].eod, !dir_rows[r].typed);
            if (dir_rows[r].typed)
                decoded_q.push_back(dir_rows[r].res);
        end

        // Random phases, each under its own error codepoint setting.
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
                settle();
            case (phase)
                1:
                begin
                    write_reg(ADDR_ERROR_CP, 32'h0000_0000);
                    write_reg(ADDR_UNMAPPED, 32'h001F_FFFF);  // must be ignored
                end
                2: write_reg(ADDR_ERROR_CP, 32'h001F_FFFF);
                3: write_reg(ADDR_ERROR_CP, 32'hFFE0_0041);  // upper bits dropped
                4:
                begin
                    rnd = $urandom;
                    write_reg(ADDR_ERROR_CP, rnd);
                end
                default: ;
            endcase
            // one phase runs with both sides streaming flat out
            calm = (phase == 2);
            if (phase == 3)
            begin
                // error value equal to a real codepoint: 'A' is still no error
                send_item(8'h41, 1'b0, 1'b1);
                send_item(8'hBF, 1'b0, 1'b1);
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
                send_random_unit(sent);
            // flush the window so the phase ends idle
            rnd = $urandom;
            send_item(rnd[7:0], 1'b1, 1'b1);
        end

        settle();
        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d items over %0d register writes, %0d results checked (%0d errors)",
                 items_sent, config_writes, results_seen, error_results);
        $display("%0d mismatches, %0d expected results never arrived",
                 mismatches, decoded_q.size());
        if (mismatches == 0 && decoded_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
